// ===== hdl/pfcc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfcc_pkg
// Shared types, command codes and constants of the page flash command
// controller: array geometry, bus command codes, status codes and the
// write-protect address sequence.
// ----------------------------------------------------------------------------
package pfcc_pkg;

  // Array geometry
  localparam int unsigned ADDR_BITS    = 19;
  localparam int unsigned ARRAY_SIZE   = 2 ** ADDR_BITS;
  localparam int unsigned SECTOR_BYTES = 256;  // power of two

  // Port widths fixed by the item format
  localparam int unsigned ADDR_PORT_W = 19;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef logic [ADDR_BITS-1:0] addr_t;

  localparam addr_t SECTOR_MASK = addr_t'(SECTOR_BYTES - 1);

  // Input item command field
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Result status field
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_PROTECTED = 2'd1;
  localparam logic [1:0] ST_BUSY      = 2'd2;
  localparam logic [1:0] ST_UNKNOWN   = 2'd3;

  // Command modes
  localparam logic [2:0] MODE_READ          = 3'd0;
  localparam logic [2:0] MODE_ERASE_SETUP   = 3'd1;
  localparam logic [2:0] MODE_PROGRAM_SETUP = 3'd2;
  localparam logic [2:0] MODE_CHIP_SETUP    = 3'd3;
  localparam logic [2:0] MODE_ID            = 3'd4;

  // Bus write command codes
  localparam logic [7:0] CODE_PROGRAM       = 8'h10;
  localparam logic [7:0] CODE_SECTOR_ERASE  = 8'h20;
  localparam logic [7:0] CODE_CHIP_ERASE    = 8'h30;
  localparam logic [7:0] CODE_READ_ID       = 8'h90;
  localparam logic [7:0] CODE_ERASE_CONFIRM = 8'hD0;
  localparam logic [7:0] CODE_RESET         = 8'hFF;

  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MANUFACTURER_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_TICKS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_TICKS     = 2'd3;

  // Write-protect sequence: six leading reads, then lock or unlock read
  localparam logic [2:0]  GUARD_DONE  = 3'd6;
  localparam logic [15:0] LOCK_ADDR   = 16'h040A;
  localparam logic [15:0] UNLOCK_ADDR = 16'h041A;

  function automatic logic [15:0] guard_addr(input logic [2:0] step);
    logic [15:0] a;
    unique case (step)
      3'd0:    a = 16'h1823;
      3'd1:    a = 16'h1820;
      3'd2:    a = 16'h1822;
      3'd3:    a = 16'h0418;
      3'd4:    a = 16'h041B;
      3'd5:    a = 16'h0419;
      default: a = 16'h0000;
    endcase
    return a;
  endfunction

  // Configuration registers as seen by the controller
  typedef struct packed {
    logic [7:0]  manufacturer_id;
    logic [7:0]  device_id;
    logic [15:0] program_ticks;
    logic [15:0] erase_ticks;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [7:0] read_data;
    logic       busy_res;
    logic [1:0] status;
    logic       protected_flag;
  } res_t;

  // Array memory access request
  typedef struct packed {
    logic       re;
    addr_t      raddr;
    logic       we;
    addr_t      waddr;
    logic [7:0] wdata;
  } mem_req_t;

endpackage

// ===== hdl/pfcc_mem.sv =====
// ----------------------------------------------------------------------------
// pfcc_mem
// Byte array of the flash device: one write port and one read port, read
// data registered in the cycle after the read request, held until the next.
// ----------------------------------------------------------------------------
module pfcc_mem (
  input  logic               clk_i,
  input  pfcc_pkg::mem_req_t req_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem_q [pfcc_pkg::ARRAY_SIZE];
  logic [7:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port, hold data between reads
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/pfcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfcc_ctrl
// Command state machine: decodes one item per pass, tracks the protect
// sequence and busy countdown, runs the array read-modify-write for byte
// program and the erase sweeps over the array memory.
// ----------------------------------------------------------------------------
module pfcc_ctrl (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           command_i,
  input  logic [pfcc_pkg::ADDR_PORT_W-1:0]     address_i,
  input  logic [7:0]                           write_data_i,
  input  pfcc_pkg::cfg_t                       cfg_i,
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output pfcc_pkg::res_t                       res_o,
  output pfcc_pkg::mem_req_t                   mem_req_o,
  input  logic [7:0]                           mem_rdata_i
);

  localparam logic [1:0] S_SWEEP = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_RESP  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [2:0]       mode_q, mode_d;
  logic [2:0]       guard_q, guard_d;
  logic             locked_q, locked_d;
  logic [15:0]      busy_left_q, busy_left_d;
  logic             toggle_q, toggle_d;
  pfcc_pkg::res_t   res_q, res_d;
  logic             rd_arr_q, rd_arr_d;
  logic             pend_prog_q, pend_prog_d;
  logic             pend_erase_q, pend_erase_d;
  pfcc_pkg::addr_t  op_addr_q, op_addr_d;
  logic [7:0]       op_data_q, op_data_d;
  pfcc_pkg::addr_t  sweep_addr_q, sweep_addr_d;
  pfcc_pkg::addr_t  sweep_end_q, sweep_end_d;

  pfcc_pkg::addr_t  addr;
  logic [31:0]      addr_w;
  logic             accept;
  logic             res_fire;

  assign addr     = pfcc_pkg::addr_t'(address_i);
  assign addr_w   = 32'(addr);
  assign accept   = in_valid_i && in_ready_o;
  assign res_fire = res_valid_o && res_ready_i;

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);

  // Result item: array byte arrives from the memory in the response cycle
  always_comb begin
    res_o = res_q;
    if (rd_arr_q) begin
      res_o.read_data = mem_rdata_i;
    end
  end

  // Memory port: read on accept, program write-back or sweep write later
  always_comb begin
    mem_req_o.re    = accept;
    mem_req_o.raddr = addr;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = sweep_addr_q;
    mem_req_o.wdata = pfcc_pkg::ERASED_BYTE;
    if (state_q == S_SWEEP) begin
      mem_req_o.we = 1'b1;
    end else if (state_q == S_RESP && res_fire && pend_prog_q) begin
      mem_req_o.we    = 1'b1;
      mem_req_o.waddr = op_addr_q;
      mem_req_o.wdata = mem_rdata_i & op_data_q;
    end
  end

  // Decode the item and sequence the passes
  always_comb begin
    logic [2:0]  mode;
    logic [7:0]  want;
    logic [1:0]  st;
    logic [7:0]  rd;

    state_d      = state_q;
    mode_d       = mode_q;
    guard_d      = guard_q;
    locked_d     = locked_q;
    busy_left_d  = busy_left_q;
    toggle_d     = toggle_q;
    res_d        = res_q;
    rd_arr_d     = rd_arr_q;
    pend_prog_d  = pend_prog_q;
    pend_erase_d = pend_erase_q;
    op_addr_d    = op_addr_q;
    op_data_d    = op_data_q;
    sweep_addr_d = sweep_addr_q;
    sweep_end_d  = sweep_end_q;
    mode         = mode_q;
    want         = pfcc_pkg::CODE_ERASE_CONFIRM;
    st           = pfcc_pkg::ST_OK;
    rd           = 8'h00;

    unique case (state_q)
      S_SWEEP: begin
        // Write erased bytes up to the end of the range
        sweep_addr_d = sweep_addr_q + pfcc_pkg::addr_t'(1);
        if (sweep_addr_q == sweep_end_q) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          rd_arr_d     = 1'b0;
          pend_prog_d  = 1'b0;
          pend_erase_d = 1'b0;
          op_addr_d    = addr;
          op_data_d    = write_data_i;
          unique case (command_i)
            pfcc_pkg::CMD_READ: begin
              if (busy_left_q != 16'd0) begin
                rd       = {1'b0, toggle_q, 6'b0};
                toggle_d = ~toggle_q;
              end else if (mode_q == pfcc_pkg::MODE_ID) begin
                rd = addr[0] ? cfg_i.device_id : cfg_i.manufacturer_id;
              end else begin
                rd_arr_d = 1'b1;
              end
              // Track the protect address sequence
              if (guard_q == pfcc_pkg::GUARD_DONE &&
                  (addr_w == 32'(pfcc_pkg::LOCK_ADDR) ||
                   addr_w == 32'(pfcc_pkg::UNLOCK_ADDR))) begin
                locked_d = (addr_w == 32'(pfcc_pkg::LOCK_ADDR));
                guard_d  = 3'd0;
              end else if (guard_q < pfcc_pkg::GUARD_DONE &&
                           addr_w == 32'(pfcc_pkg::guard_addr(guard_q))) begin
                guard_d = guard_q + 3'd1;
              end else if (addr_w == 32'(pfcc_pkg::guard_addr(3'd0))) begin
                guard_d = 3'd1;
              end else begin
                guard_d = 3'd0;
              end
            end

            pfcc_pkg::CMD_WRITE: begin
              if (busy_left_q != 16'd0) begin
                st = pfcc_pkg::ST_BUSY;
              end else begin
                guard_d = 3'd0;
                mode_d  = pfcc_pkg::MODE_READ;
                case (mode) inside
                  pfcc_pkg::MODE_PROGRAM_SETUP: begin
                    if (locked_q) begin
                      st = pfcc_pkg::ST_PROTECTED;
                    end else begin
                      pend_prog_d = 1'b1;
                      busy_left_d = cfg_i.program_ticks;
                    end
                  end
                  pfcc_pkg::MODE_ERASE_SETUP, pfcc_pkg::MODE_CHIP_SETUP: begin
                    if (mode == pfcc_pkg::MODE_CHIP_SETUP) begin
                      want = pfcc_pkg::CODE_CHIP_ERASE;
                    end
                    if (write_data_i == pfcc_pkg::CODE_RESET) begin
                      st = pfcc_pkg::ST_OK;
                    end else if (write_data_i != want) begin
                      st = pfcc_pkg::ST_UNKNOWN;
                    end else if (locked_q) begin
                      st = pfcc_pkg::ST_PROTECTED;
                    end else begin
                      pend_erase_d = 1'b1;
                      busy_left_d  = cfg_i.erase_ticks;
                      if (mode == pfcc_pkg::MODE_CHIP_SETUP) begin
                        sweep_addr_d = '0;
                        sweep_end_d  = '1;
                      end else begin
                        sweep_addr_d = addr & ~pfcc_pkg::SECTOR_MASK;
                        sweep_end_d  = addr | pfcc_pkg::SECTOR_MASK;
                      end
                    end
                  end
                  default: begin
                    unique case (write_data_i)
                      pfcc_pkg::CODE_SECTOR_ERASE:
                        mode_d = pfcc_pkg::MODE_ERASE_SETUP;
                      pfcc_pkg::CODE_PROGRAM:
                        mode_d = pfcc_pkg::MODE_PROGRAM_SETUP;
                      pfcc_pkg::CODE_CHIP_ERASE:
                        mode_d = pfcc_pkg::MODE_CHIP_SETUP;
                      pfcc_pkg::CODE_READ_ID:
                        mode_d = pfcc_pkg::MODE_ID;
                      pfcc_pkg::CODE_RESET:
                        st = pfcc_pkg::ST_OK;
                      default:
                        st = pfcc_pkg::ST_UNKNOWN;
                    endcase
                  end
                endcase
              end
            end

            pfcc_pkg::CMD_TICK: begin
              if (busy_left_q != 16'd0) begin
                busy_left_d = busy_left_q - 16'd1;
              end
            end

            default: begin
              st = pfcc_pkg::ST_UNKNOWN;
            end
          endcase

          res_d.read_data      = rd;
          res_d.busy_res       = (busy_left_d != 16'd0);
          res_d.status         = st;
          res_d.protected_flag = locked_d;
          state_d              = S_RESP;
        end
      end

      S_RESP: begin
        // Hand over the result, then sweep if an erase was taken
        if (res_fire) begin
          state_d = pend_erase_q ? S_SWEEP : S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state; reset starts a clearing sweep over the whole array
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      mode_q       <= pfcc_pkg::MODE_READ;
      guard_q      <= 3'd0;
      locked_q     <= 1'b1;
      busy_left_q  <= 16'd0;
      toggle_q     <= 1'b0;
      rd_arr_q     <= 1'b0;
      pend_prog_q  <= 1'b0;
      pend_erase_q <= 1'b0;
      sweep_addr_q <= '0;
      sweep_end_q  <= '1;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      guard_q      <= guard_d;
      locked_q     <= locked_d;
      busy_left_q  <= busy_left_d;
      toggle_q     <= toggle_d;
      rd_arr_q     <= rd_arr_d;
      pend_prog_q  <= pend_prog_d;
      pend_erase_q <= pend_erase_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_end_q  <= sweep_end_d;
    end
  end

  // Payload of the item in flight
  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    op_addr_q <= op_addr_d;
    op_data_q <= op_data_d;
  end

endmodule

// ===== hdl/page_flash_command_controller.sv =====
// ----------------------------------------------------------------------------
// page_flash_command_controller
// Byte-wide flash device model: configuration registers, command controller,
// array memory and an output register between the controller and the sink.
// ----------------------------------------------------------------------------
// Path: the array is read and the result registered on accept; it then
//   enters the output register when empty or draining, and is held there.
// Flow: a new item waits until the result is handed over. An accepted sector
//   erase then writes SECTOR_BYTES (256) bytes and a chip erase 524288 bytes.
// Reset: a clearing pass writes 0xFF to all 524288 bytes, one a cycle, with
//   in_ready_o low; configuration writes are taken throughout.
module page_flash_command_controller (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         command_i,
  input  logic [pfcc_pkg::ADDR_PORT_W-1:0]   address_i,
  input  logic [7:0]                         write_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [7:0]                         read_data_o,
  output logic                               busy_res_o,
  output logic [1:0]                         status_o,
  output logic                               protected_flag_o,
  input  logic                               cfg_we_i,
  input  logic [pfcc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pfcc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  pfcc_pkg::cfg_t     cfg_q;
  pfcc_pkg::res_t     res;
  pfcc_pkg::res_t     out_q;
  pfcc_pkg::mem_req_t mem_req;
  logic [7:0]         mem_rdata;
  logic               res_valid;
  logic               res_ready;
  logic               out_valid_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.manufacturer_id <= 8'd191;
      cfg_q.device_id       <= 8'd4;
      cfg_q.program_ticks   <= 16'd20;
      cfg_q.erase_ticks     <= 16'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pfcc_pkg::CFG_MANUFACTURER_ID: cfg_q.manufacturer_id <= cfg_data_i[7:0];
        pfcc_pkg::CFG_DEVICE_ID:       cfg_q.device_id       <= cfg_data_i[7:0];
        pfcc_pkg::CFG_PROGRAM_TICKS:   cfg_q.program_ticks   <= cfg_data_i;
        pfcc_pkg::CFG_ERASE_TICKS:     cfg_q.erase_ticks     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pfcc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .cfg_i        (cfg_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata)
  );

  pfcc_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Output register: take a result when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = out_q.read_data;
  assign busy_res_o       = out_q.busy_res;
  assign status_o         = out_q.status;
  assign protected_flag_o = out_q.protected_flag;

  // No new item while a result is still pending in the controller
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !res_valid)
    else $error("item accepted while a result is pending");

  // Array reads happen only at accept, never alongside a write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.we && mem_req.re))
    else $error("array read and write in the same cycle");

  // A handed-over result shows up at the outputs next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> out_valid_o)
    else $error("result lost in output register");

endmodule

// ===== tb/page_flash_command_controller_test.sv =====
// ----------------------------------------------------------------------------
// page_flash_command_controller_test
// Self-checking bench for the page flash command controller. A directed
// table of bus commands runs first, followed by randomized command sequences
// under several register settings and idling patterns. Every result item is
// compared field by field with its table value or the in-bench device model.
// ----------------------------------------------------------------------------
module page_flash_command_controller_test;
  import pfcc_pkg::*;

  localparam logic [1:0]  CMD_NONE      = 2'd3;  // undefined bus command
  localparam int unsigned STALL_LIMIT   = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 400;

  // Leading reads of the protect sequence, step 0 in the low bits
  localparam logic [6*16-1:0] GUARD_SEQ = {16'h0419, 16'h041B, 16'h0418,
                                           16'h1822, 16'h1820, 16'h1823};

  typedef struct packed {
    logic [1:0] cmd;
    addr_t      addr;
    logic [7:0] data;
  } bus_op_t;

  typedef struct {
    bus_op_t op;
    bit      fixed;
    res_t    want;
  } dir_row_t;

  logic                   clk_i        = 1'b0;
  logic                   rst_ni       = 1'b0;
  logic                   in_valid_i   = 1'b0;
  logic                   in_ready_o;
  logic [1:0]             command_i    = CMD_READ;
  logic [ADDR_PORT_W-1:0] address_i    = '0;
  logic [7:0]             write_data_i = 8'h00;
  logic                   out_valid_o;
  logic                   out_ready_i  = 1'b0;
  logic [7:0]             read_data_o;
  logic                   busy_res_o;
  logic [1:0]             status_o;
  logic                   protected_flag_o;
  logic                   cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i  = CFG_MANUFACTURER_ID;
  logic [CFG_DATA_W-1:0]  cfg_data_i   = '0;

  // Device model state and register copies
  logic [7:0]  flash_mem [ARRAY_SIZE];
  logic [2:0]  dev_mode;
  logic [2:0]  guard_step;
  logic        wp_latch;
  logic [15:0] busy_count;
  logic        toggle_q;
  logic [7:0]  mfr_id;
  logic [7:0]  dev_id;
  logic [15:0] prog_ticks;
  logic [15:0] erase_ticks;
  int unsigned walk_cycles;

  res_t        pending_results [$];
  bus_op_t     plan_q [$];
  dir_row_t    dir_rows [$];
  res_t        oldest;

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned holds_started  = 0;
  int unsigned hold_left      = 0;
  int unsigned idle_cycles    = 0;
  int unsigned items_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned errors         = 0;

  page_flash_command_controller dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .address_i        (address_i),
    .write_data_i     (write_data_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .read_data_o      (read_data_o),
    .busy_res_o       (busy_res_o),
    .status_o         (status_o),
    .protected_flag_o (protected_flag_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bus_op_t op_of(logic [1:0] cmd, addr_t a, logic [7:0] d);
    bus_op_t op;
    op.cmd  = cmd;
    op.addr = a;
    op.data = d;
    return op;
  endfunction

  // Advance the device model by one item and return its result
  function automatic res_t flash_response(bus_op_t op);
    res_t       r;
    logic [2:0] was_mode;
    logic [7:0] confirm;
    addr_t      base;
    r = '0;
    r.status = ST_OK;
    walk_cycles = 0;
    case (op.cmd)
      CMD_READ: begin
        if (busy_count != 16'd0) begin
          r.read_data = {1'b0, toggle_q, 6'b000000};
          toggle_q = ~toggle_q;
        end else if (dev_mode == MODE_ID) begin
          r.read_data = op.addr[0] ? dev_id : mfr_id;
        end else begin
          r.read_data = flash_mem[op.addr];
        end
        // track the protect sequence; a stray read restarts it
        if (guard_step == GUARD_DONE &&
            (op.addr == addr_t'(LOCK_ADDR) || op.addr == addr_t'(UNLOCK_ADDR))) begin
          wp_latch = (op.addr == addr_t'(LOCK_ADDR));
          guard_step = 3'd0;
        end else if (guard_step < GUARD_DONE &&
                     op.addr == addr_t'(GUARD_SEQ[guard_step*16 +: 16])) begin
          guard_step = guard_step + 3'd1;
        end else begin
          guard_step = (op.addr == addr_t'(GUARD_SEQ[15:0])) ? 3'd1 : 3'd0;
        end
      end
      CMD_WRITE: begin
        if (busy_count != 16'd0) begin
          r.status = ST_BUSY;
        end else begin
          guard_step = 3'd0;
          was_mode = dev_mode;
          dev_mode = MODE_READ;
          case (was_mode)
            MODE_PROGRAM_SETUP: begin
              if (wp_latch) begin
                r.status = ST_PROTECTED;
              end else begin
                flash_mem[op.addr] = flash_mem[op.addr] & op.data;
                busy_count = prog_ticks;
              end
            end
            MODE_ERASE_SETUP, MODE_CHIP_SETUP: begin
              confirm = (was_mode == MODE_ERASE_SETUP) ? CODE_ERASE_CONFIRM
                                                       : CODE_CHIP_ERASE;
              if (op.data == CODE_RESET) begin
                r.status = ST_OK;
              end else if (op.data != confirm) begin
                r.status = ST_UNKNOWN;
              end else if (wp_latch) begin
                r.status = ST_PROTECTED;
              end else if (was_mode == MODE_CHIP_SETUP) begin
                for (int i = 0; i < int'(ARRAY_SIZE); i++) flash_mem[i] = ERASED_BYTE;
                busy_count = erase_ticks;
                walk_cycles = ARRAY_SIZE;
              end else begin
                // clear the sector, cut at the end of the array
                base = op.addr & ~SECTOR_MASK;
                for (int i = 0; i < int'(SECTOR_BYTES) &&
                     int'(base) + i < int'(ARRAY_SIZE); i++) begin
                  flash_mem[base + addr_t'(i)] = ERASED_BYTE;
                end
                busy_count = erase_ticks;
                walk_cycles = SECTOR_BYTES;
              end
            end
            default: begin
              case (op.data)
                CODE_SECTOR_ERASE: dev_mode = MODE_ERASE_SETUP;
                CODE_PROGRAM:      dev_mode = MODE_PROGRAM_SETUP;
                CODE_CHIP_ERASE:   dev_mode = MODE_CHIP_SETUP;
                CODE_READ_ID:      dev_mode = MODE_ID;
                CODE_RESET:        dev_mode = MODE_READ;
                default:           r.status = ST_UNKNOWN;
              endcase
            end
          endcase
        end
      end
      CMD_TICK: begin
        if (busy_count != 16'd0) busy_count = busy_count - 16'd1;
      end
      default: r.status = ST_UNKNOWN;
    endcase
    r.busy_res = (busy_count != 16'd0);
    r.protected_flag = wp_latch;
    return r;
  endfunction

  // Favor the low sectors, the last sectors and the protect addresses
  function automatic addr_t pick_addr();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) return addr_t'($urandom_range(1023));
    if (sel < 70) return addr_t'(ARRAY_SIZE - 1 - $urandom_range(511));
    if (sel < 80) return addr_t'(GUARD_SEQ[$urandom_range(5)*16 +: 16]);
    return addr_t'($urandom);
  endfunction

  // Draw the next random item, mostly from well-formed command sequences
  function automatic bus_op_t next_random_op();
    bus_op_t     op;
    addr_t       a;
    int unsigned kind;
    // drain busy periods with ticks
    if (busy_count != 16'd0 && $urandom_range(1) == 0) begin
      return op_of(CMD_TICK, addr_t'($urandom), 8'($urandom));
    end
    if (plan_q.size() == 0) begin
      kind = $urandom_range(99);
      a = pick_addr();
      if (kind < 15) begin
        for (int k = 0; k < 6; k++) begin
          plan_q.push_back(op_of(CMD_READ, ($urandom_range(19) == 0) ? pick_addr()
                                 : addr_t'(GUARD_SEQ[k*16 +: 16]), 8'($urandom)));
        end
        plan_q.push_back(op_of(CMD_READ, ($urandom_range(99) < 65) ? addr_t'(UNLOCK_ADDR)
                               : addr_t'(LOCK_ADDR), 8'($urandom)));
      end else if (kind < 35) begin
        plan_q.push_back(op_of(CMD_WRITE, addr_t'($urandom), CODE_PROGRAM));
        plan_q.push_back(op_of(CMD_WRITE, a, 8'($urandom)));
        plan_q.push_back(op_of(CMD_READ, a, 8'($urandom)));
      end else if (kind < 50) begin
        plan_q.push_back(op_of(CMD_WRITE, addr_t'($urandom), CODE_SECTOR_ERASE));
        plan_q.push_back(op_of(CMD_WRITE, a, ($urandom_range(9) == 0) ? 8'($urandom)
                               : CODE_ERASE_CONFIRM));
        plan_q.push_back(op_of(CMD_READ, a ^ addr_t'($urandom_range(255)), 8'($urandom)));
      end else if (kind < 55) begin
        plan_q.push_back(op_of(CMD_WRITE, addr_t'($urandom), CODE_CHIP_ERASE));
        plan_q.push_back(op_of(CMD_WRITE, a, ($urandom_range(1) == 0) ? 8'($urandom)
                               : CODE_CHIP_ERASE));
      end else if (kind < 63) begin
        plan_q.push_back(op_of(CMD_WRITE, addr_t'($urandom), CODE_READ_ID));
        plan_q.push_back(op_of(CMD_READ, a, 8'($urandom)));
        plan_q.push_back(op_of(CMD_READ, a ^ addr_t'(1), 8'($urandom)));
        plan_q.push_back(op_of(CMD_WRITE, a, ($urandom_range(1) == 0) ? 8'($urandom)
                               : CODE_RESET));
      end else if (kind < 78) begin
        repeat ($urandom_range(4, 1)) plan_q.push_back(op_of(CMD_READ, pick_addr(),
                                                              8'($urandom)));
      end else if (kind < 88) begin
        repeat ($urandom_range(6, 1)) plan_q.push_back(op_of(CMD_TICK, addr_t'($urandom),
                                                              8'($urandom)));
      end else begin
        plan_q.push_back(op_of(2'($urandom), addr_t'($urandom), 8'($urandom)));
      end
    end
    op = plan_q.pop_front();
    // keep the one full chip erase to the directed part
    if (op.cmd == CMD_WRITE && busy_count == 16'd0 && dev_mode == MODE_CHIP_SETUP &&
        !wp_latch && op.data == CODE_CHIP_ERASE) begin
      op.data = CODE_RESET;
    end
    return op;
  endfunction

  // Offer one item, hold it until accepted, then predict its result
  task automatic send_op(bus_op_t op, bit fixed, res_t want);
    res_t guess;
    if (src_idle_pct != 0) begin
      while ($urandom_range(99) < src_idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    command_i    <= op.cmd;
    address_i    <= op.addr;
    write_data_i <= op.data;
    do @(posedge clk_i); while (!in_ready_o);
    guess = flash_response(op);
    pending_results.push_back(fixed ? want : guess);
    items_sent++;
  endtask

  task automatic row(bit fixed, logic [1:0] cmd, addr_t a, logic [7:0] d,
                     logic [7:0] rd, logic busy, logic [1:0] st, logic prot);
    dir_row_t r;
    r.op    = op_of(cmd, a, d);
    r.fixed = fixed;
    r.want  = {rd, busy, st, prot};
    dir_rows.push_back(r);
  endtask

  // Wait out every pending result and any erase walk still in progress
  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES + walk_cycles) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      CFG_MANUFACTURER_ID: mfr_id      = value[7:0];
      CFG_DEVICE_ID:       dev_id      = value[7:0];
      CFG_PROGRAM_TICKS:   prog_ticks  = value;
      default:             erase_ticks = value;
    endcase
  endtask

  task automatic configure(logic [7:0] mfr, logic [7:0] dev, logic [15:0] prog,
                           logic [15:0] erase);
    set_reg(CFG_MANUFACTURER_ID, {8'h00, mfr});
    set_reg(CFG_DEVICE_ID, {8'h00, dev});
    set_reg(CFG_PROGRAM_TICKS, prog);
    set_reg(CFG_ERASE_TICKS, erase);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(int unsigned n, int unsigned src_pct, int unsigned sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (n) send_op(next_random_op(), 1'b0, '0);
    in_valid_i <= 1'b0;
    wait_drained();
  endtask

  task automatic report_field(string field, int unsigned want_v, int unsigned got_v);
    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want_v, got_v);
    errors++;
  endtask

  // Drive the result ready: random stalls plus an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_requests != holds_started) begin
      holds_started <= holds_started + 1;
      hold_left     <= HOLD_CYCLES;
      out_ready_i   <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result item with none expected: read_data %0h status %0h",
                 $time, read_data_o, status_o);
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        if (read_data_o !== oldest.read_data)
          report_field("read_data", oldest.read_data, read_data_o);
        if (busy_res_o !== oldest.busy_res)
          report_field("busy_res", oldest.busy_res, busy_res_o);
        if (status_o !== oldest.status)
          report_field("status", oldest.status, status_o);
        if (protected_flag_o !== oldest.protected_flag)
          report_field("protected_flag", oldest.protected_flag, protected_flag_o);
      end
    end
  end

  // Stop a run in which no item moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: watchdog: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("page_flash_command_controller test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < int'(ARRAY_SIZE); i++) flash_mem[i] = ERASED_BYTE;
    dev_mode    = MODE_READ;
    guard_step  = 3'd0;
    wp_latch    = 1'b1;
    busy_count  = 16'd0;
    toggle_q    = 1'b0;
    mfr_id      = 8'd191;
    dev_id      = 8'd4;
    prog_ticks  = 16'd20;
    erase_ticks = 16'd1000;
    walk_cycles = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // shorten erase busy periods; the other registers keep their reset values
    set_reg(CFG_ERASE_TICKS, 16'd2);
    cfg_we_i <= 1'b0;

    // fixed cmd         address   data   read   busy  status        prot
    row(1, CMD_READ,  19'h00000, 8'h00, 8'hFF, 1'b0, ST_OK,        1'b1);
    row(1, CMD_WRITE, 19'h7FFFF, 8'h90, 8'h00, 1'b0, ST_OK,        1'b1);
    row(1, CMD_READ,  19'h7FFFE, 8'hFF, 8'hBF, 1'b0, ST_OK,        1'b1);
    row(1, CMD_READ,  19'h7FFFF, 8'h00, 8'h04, 1'b0, ST_OK,        1'b1);
    row(1, CMD_WRITE, 19'h00000, 8'h55, 8'h00, 1'b0, ST_UNKNOWN,   1'b1);
    row(0, CMD_WRITE, 19'h00100, 8'h10, 8'h00, 1'b0, ST_OK,        1'b0);
    row(1, CMD_WRITE, 19'h00100, 8'h00, 8'h00, 1'b0, ST_PROTECTED, 1'b1);
    row(0, CMD_WRITE, 19'h7FF80, 8'h20, 8'h00, 1'b0, ST_OK,        1'b0);
    row(1, CMD_WRITE, 19'h7FF80, 8'hD0, 8'h00, 1'b0, ST_PROTECTED, 1'b1);
    row(0, CMD_WRITE, 19'h00000, 8'h30, 8'h00, 1'b0, ST_OK,        1'b0);
    row(1, CMD_WRITE, 19'h00000, 8'h77, 8'h00, 1'b0, ST_UNKNOWN,   1'b1);
    row(0, CMD_WRITE, 19'h00000, 8'h20, 8'h00, 1'b0, ST_OK,        1'b0);
    row(1, CMD_WRITE, 19'h00000, 8'hFF, 8'h00, 1'b0, ST_OK,        1'b1);
    row(1, CMD_NONE,  19'h7FFFF, 8'hFF, 8'h00, 1'b0, ST_UNKNOWN,   1'b1);
    // unlock sequence
    row(0, CMD_READ,  19'h01823, 8'h00, 8'h00, 1'b0, ST_OK,        1'b0);
    row(0, CMD_READ,  19'h01820, 8'h00, 8'h00, 1'b0, ST_OK,        1'b0);
    row(0, CMD_READ,  19'h01822, 8'h00, 8'h00, 1'b0, ST_OK,        1'b0);
    row(0, CMD_READ,  19'h00418, 8'h00, 8'h00, 1'b0, ST_OK,        1'b0);
    row(0, CMD_READ,  19'h0041B, 8'h00, 8'h00, 1'b0, ST_OK,        1'b0);
    row(0, CMD_READ,  19'h00419, 8'h00, 8'h00, 1'b0, ST_OK,        1'b0);
    row(0, CMD_READ,  19'h0041A, 8'h00, 8'h00, 1'b0, ST_OK,        1'b0);
    // chip erase, then the busy period it starts
    row(0, CMD_WRITE, 19'h00000, 8'h30, 8'h00, 1'b0, ST_OK,        1'b0);
    row(0, CMD_WRITE, 19'h00000, 8'h30, 8'h00, 1'b0, ST_OK,        1'b0);
    row(0, CMD_READ,  19'h00055, 8'h00, 8'h00, 1'b0, ST_OK,        1'b0);
    row(1, CMD_WRITE, 19'h00000, 8'h20, 8'h00, 1'b1, ST_BUSY,      1'b0);
    row(0, CMD_TICK,  19'h00000, 8'h00, 8'h00, 1'b0, ST_OK,        1'b0);
    row(0, CMD_TICK,  19'h7FFFF, 8'hFF, 8'h00, 1'b0, ST_OK,        1'b0);
    row(0, CMD_READ,  19'h7FFFF, 8'h00, 8'h00, 1'b0, ST_OK,        1'b0);

    foreach (dir_rows[i]) send_op(dir_rows[i].op, dir_rows[i].fixed, dir_rows[i].want);
    in_valid_i <= 1'b0;
    wait_drained();

    // reset IDs and program time, no idling
    run_phase(160, 0, 0);
    configure(8'h00, 8'hFF, 16'd1, 16'd5);
    run_phase(160, 70, 0);
    // zero busy times
    configure(8'hFF, 8'h00, 16'd0, 16'd0);
    run_phase(160, 0, 70);
    // mid values with a long receiver hold-off at the start
    configure(8'($urandom), 8'($urandom), 16'($urandom_range(9, 2)),
              16'($urandom_range(12, 1)));
    hold_requests++;
    run_phase(140, 37, 37);
    // longest busy times; the device stays busy once an operation starts
    configure(8'($urandom), 8'($urandom), 16'hFFFF, 16'hFFFF);
    run_phase(80, 0, 0);

    $display("Sent %0d items over five register settings and four idling patterns; %0d results compared.",
             items_sent, results_seen);
    $display("Exercised ID reads, protect sequences, program, sector and chip erase, busy and refusals.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("page_flash_command_controller test passed");
    end else begin
      $display("page_flash_command_controller test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pfcc_pkg.sv
hdl/pfcc_mem.sv
hdl/pfcc_ctrl.sv
hdl/page_flash_command_controller.sv
tb/page_flash_command_controller_test.sv
